// ----- src/qrv_pkg.sv -----
`timescale 1ns / 1ps

package qrv_pkg;

    localparam int LANES   = 3;
    localparam int QIN_W   = 16;
    localparam int QP_W    = 17;
    localparam int VIN_W   = 32;
    localparam int VT_W    = 37;
    localparam int PROD_W  = QP_W + VT_W;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int WP_W    = QIN_W + VT_W;
    localparam int SUM_W   = 40;
    localparam int T_SHIFT = 13;
    localparam int R_SHIFT = 14;

    typedef logic signed [QIN_W-1:0]  t_wpart;
    typedef logic signed [QP_W-1:0]   t_qpart;
    typedef logic signed [VIN_W-1:0]  t_out;
    typedef logic signed [VT_W-1:0]   t_vpart;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [WP_W-1:0]   t_wprod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_out OUT_MAX = {1'b0, {(VIN_W-1){1'b1}}};
    localparam t_out OUT_MIN = {1'b1, {(VIN_W-1){1'b0}}};

endpackage

// ----- src/qrv_in_if.sv -----
`timescale 1ns / 1ps

interface qrv_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;

    modport source (
        output valid, operation, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, operation, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// ----- src/qrv_out_if.sv -----
`timescale 1ns / 1ps

interface qrv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

// ----- src/qrv_cross_mul.sv -----
`timescale 1ns / 1ps

module qrv_cross_mul
    import qrv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_qpart i_a [LANES],
    input  t_vpart i_b [LANES],
    output t_prod  o_pos [LANES],
    output t_prod  o_neg [LANES]
);

    t_prod r_pos [LANES];
    t_prod r_neg [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        localparam int J = (g + 1) % LANES;
        localparam int K = (g + 2) % LANES;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pos[g] <= i_a[J] * i_b[K];
                r_neg[g] <= i_a[K] * i_b[J];
            end
        end

        assign o_pos[g] = r_pos[g];
        assign o_neg[g] = r_neg[g];
    end

endmodule

// ----- src/quaternion_rotate_vector.sv -----
`timescale 1ns / 1ps
// An accepted input word moves through stages 1 to 6 in order to its result word on o_out.
// Throughput: one word per cycle; each of the six stages holds its own word
// and stalls only when the stage after it is full and held.
// Reset (i_rst_n low, synchronous) empties every stage; i_in.ready is low
// while reset is held. Datapath registers are not reset.

module quaternion_rotate_vector
    import qrv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    qrv_in_if.sink    i_in,
    qrv_out_if.source o_out
);

    logic [6:1] r_v;
    logic [6:1] en;

    t_qpart r_q1 [LANES];
    t_wpart r_w1;
    t_vpart r_v1 [LANES];

    t_qpart r_q2 [LANES];
    t_wpart r_w2;
    t_vpart r_v2 [LANES];
    t_prod  p2_pos [LANES];
    t_prod  p2_neg [LANES];

    t_qpart r_q3 [LANES];
    t_wpart r_w3;
    t_vpart r_v3 [LANES];
    t_vpart r_t3 [LANES];
    t_vpart n_t3 [LANES];

    t_vpart r_v4 [LANES];
    t_wprod r_wt4 [LANES];
    t_prod  p4_pos [LANES];
    t_prod  p4_neg [LANES];

    t_sum   r_s5 [LANES];
    t_sum   n_s5 [LANES];

    t_out   r_o6 [LANES];
    logic   r_sat6;
    t_out   n_o6 [LANES];
    logic   n_sat6;

    t_qpart n_q1 [LANES];
    t_vpart n_v1 [LANES];

    // stall chain: a stage takes a word when empty or when the next one moves
    always_comb begin
        en[6] = !r_v[6] || o_out.ready;
        en[5] = !r_v[5] || en[6];
        en[4] = !r_v[4] || en[5];
        en[3] = !r_v[3] || en[4];
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
    end

    assign i_in.ready = en[1] && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_in.valid;
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
            if (en[4]) r_v[4] <= r_v[3];
            if (en[5]) r_v[5] <= r_v[4];
            if (en[6]) r_v[6] <= r_v[5];
        end
    end

    // stage 1: widen, and conjugate when i_in.operation is set
    always_comb begin
        n_q1[0] = {i_in.quat_x[QIN_W-1], i_in.quat_x};
        n_q1[1] = {i_in.quat_y[QIN_W-1], i_in.quat_y};
        n_q1[2] = {i_in.quat_z[QIN_W-1], i_in.quat_z};
        if (i_in.operation) begin
            for (int i = 0; i < LANES; i++) n_q1[i] = -n_q1[i];
        end
        n_v1[0] = t_vpart'(i_in.vec_x);
        n_v1[1] = t_vpart'(i_in.vec_y);
        n_v1[2] = t_vpart'(i_in.vec_z);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_q1 <= n_q1;
            r_w1 <= i_in.quat_w;
            r_v1 <= n_v1;
        end
    end

    // stage 2: q x v products
    qrv_cross_mul u_mul_qv (
        .i_clk (i_clk),
        .i_en  (en[2]),
        .i_a   (r_q1),
        .i_b   (r_v1),
        .o_pos (p2_pos),
        .o_neg (p2_neg)
    );

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_q2 <= r_q1;
            r_w2 <= r_w1;
            r_v2 <= r_v1;
        end
    end

    // stage 3: T = 2 (q x v), floored
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_t3[i] = t_vpart'(t_diff'(t_diff'(p2_pos[i]) - t_diff'(p2_neg[i])) >>> T_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_q3 <= r_q2;
            r_w3 <= r_w2;
            r_v3 <= r_v2;
            r_t3 <= n_t3;
        end
    end

    // stage 4: q x T and w * T products
    qrv_cross_mul u_mul_qt (
        .i_clk (i_clk),
        .i_en  (en[4]),
        .i_a   (r_q3),
        .i_b   (r_t3),
        .o_pos (p4_pos),
        .o_neg (p4_neg)
    );

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_v4 <= r_v3;
            for (int i = 0; i < LANES; i++) r_wt4[i] <= r_w3 * r_t3[i];
        end
    end

    // stage 5: rescale and sum
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_s5[i] = t_sum'(r_v4[i])
                    + t_sum'(r_wt4[i] >>> R_SHIFT)
                    + t_sum'(t_diff'(t_diff'(p4_pos[i]) - t_diff'(p4_neg[i])) >>> R_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) r_s5 <= n_s5;
    end

    // stage 6: clamp to 32 bits
    always_comb begin
        n_sat6 = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            if ((&r_s5[i][SUM_W-1:VIN_W-1]) || !(|r_s5[i][SUM_W-1:VIN_W-1])) begin
                n_o6[i] = r_s5[i][VIN_W-1:0];
            end else begin
                n_o6[i] = r_s5[i][SUM_W-1] ? OUT_MIN : OUT_MAX;
                n_sat6  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_o6   <= n_o6;
            r_sat6 <= n_sat6;
        end
    end

    assign o_out.valid     = r_v[6];
    assign o_out.out_x     = r_o6[0];
    assign o_out.out_y     = r_o6[1];
    assign o_out.out_z     = r_o6[2];
    assign o_out.saturated = r_sat6;

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v[1])
        else $error("accepted word not captured in stage 1");

    a_free_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !o_out.valid |-> i_in.ready)
        else $error("input blocked while output stage is empty");

    a_stall_holds_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && !en[4] |=> r_v[3] && $stable(r_t3[0]) && $stable(r_t3[1])
                             && $stable(r_t3[2]))
        else $error("stalled stage 3 word changed");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |->
            o_out.out_x == OUT_MAX || o_out.out_x == OUT_MIN ||
            o_out.out_y == OUT_MAX || o_out.out_y == OUT_MIN ||
            o_out.out_z == OUT_MAX || o_out.out_z == OUT_MIN)
        else $error("saturated flag without a clamped component");

endmodule

// ----- verif/qrv_tb_pkg.sv -----
`timescale 1ns / 1ps

package qrv_tb_pkg;

    import qrv_pkg::*;

    typedef enum logic {
        OP_ROTATE  = 1'b0,
        OP_INVERSE = 1'b1
    } rot_op_t;

    typedef struct packed {
        rot_op_t op;
        t_wpart  quat_x;
        t_wpart  quat_y;
        t_wpart  quat_z;
        t_wpart  quat_w;
        t_out    vec_x;
        t_out    vec_y;
        t_out    vec_z;
    } rot_word_t;

    typedef struct packed {
        t_out out_x;
        t_out out_y;
        t_out out_z;
        logic saturated;
    } rot_result_t;

endpackage

// ----- verif/qrv_checker.sv -----
`timescale 1ns / 1ps

module qrv_checker
    import qrv_pkg::*;
    import qrv_tb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    qrv_in_if    i_in,
    qrv_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);

    rot_result_t pending_rotations[$];
    int          error_count = 0;
    int          pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic rot_result_t rotated_vector(input rot_word_t w);
        longint      q[3];
        longint      v[3];
        longint      t[3];
        longint      r[3];
        longint      qw;
        longint      wt;
        longint      qt;
        int          i;
        int          j;
        int          k;
        rot_result_t res;
        q[0] = $signed(w.quat_x);
        q[1] = $signed(w.quat_y);
        q[2] = $signed(w.quat_z);
        v[0] = $signed(w.vec_x);
        v[1] = $signed(w.vec_y);
        v[2] = $signed(w.vec_z);
        qw   = $signed(w.quat_w);
        if (w.op == OP_INVERSE) begin
            for (i = 0; i < 3; i++) q[i] = -q[i];
        end
        for (i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            t[i] = (q[j] * v[k] - q[k] * v[j]) >>> T_SHIFT;
        end
        res.saturated = 1'b0;
        for (i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            wt = (qw * t[i]) >>> R_SHIFT;
            qt = (q[j] * t[k] - q[k] * t[j]) >>> R_SHIFT;
            r[i] = v[i] + wt + qt;
            if (r[i] > longint'(OUT_MAX)) begin
                r[i] = OUT_MAX;
                res.saturated = 1'b1;
            end else if (r[i] < longint'(OUT_MIN)) begin
                r[i] = OUT_MIN;
                res.saturated = 1'b1;
            end
        end
        res.out_x = t_out'(r[0]);
        res.out_y = t_out'(r[1]);
        res.out_z = t_out'(r[2]);
        return res;
    endfunction

    always @(posedge i_clk) begin
        rot_word_t   w;
        rot_result_t e;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                w.op     = rot_op_t'(i_in.operation);
                w.quat_x = i_in.quat_x;
                w.quat_y = i_in.quat_y;
                w.quat_z = i_in.quat_z;
                w.quat_w = i_in.quat_w;
                w.vec_x  = i_in.vec_x;
                w.vec_y  = i_in.vec_y;
                w.vec_z  = i_in.vec_z;
                pending_rotations.push_back(rotated_vector(w));
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_rotations.size() == 0) begin
                    $error("result word with no rotation pending");
                    error_count++;
                end else begin
                    e = pending_rotations.pop_front();
                    if (i_out.out_x !== e.out_x) begin
                        $error("out_x mismatch: expected %0d, got %0d", e.out_x, i_out.out_x);
                        error_count++;
                    end
                    if (i_out.out_y !== e.out_y) begin
                        $error("out_y mismatch: expected %0d, got %0d", e.out_y, i_out.out_y);
                        error_count++;
                    end
                    if (i_out.out_z !== e.out_z) begin
                        $error("out_z mismatch: expected %0d, got %0d", e.out_z, i_out.out_z);
                        error_count++;
                    end
                    if (i_out.saturated !== e.saturated) begin
                        $error("saturated mismatch: expected %0d, got %0d",
                               e.saturated, i_out.saturated);
                        error_count++;
                    end
                end
            end
        end
        pending_count = pending_rotations.size();
    end

endmodule

// ----- verif/tb_quaternion_rotate_vector.sv -----
`timescale 1ns / 1ps

module tb_quaternion_rotate_vector;

    import qrv_pkg::*;
    import qrv_tb_pkg::*;

    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 64;
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_CYCLES = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   rotations_in_flight;
    int   cycle_count = 0;
    int   words_sent = 0;
    bit   tx_quiet;
    bit   rx_quiet;

    qrv_in_if  in_ch ();
    qrv_out_if out_ch ();

    quaternion_rotate_vector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    qrv_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (fail_count),
        .o_pending (rotations_in_flight)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic rot_word_t word_of(input rot_op_t op,
                                          input t_wpart qx, input t_wpart qy,
                                          input t_wpart qz, input t_wpart qw,
                                          input t_out vx, input t_out vy, input t_out vz);
        rot_word_t w;
        w.op     = op;
        w.quat_x = qx;
        w.quat_y = qy;
        w.quat_z = qz;
        w.quat_w = qw;
        w.vec_x  = vx;
        w.vec_y  = vy;
        w.vec_z  = vz;
        return w;
    endfunction

    function automatic t_wpart corner16();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return t_wpart'($urandom);
        endcase
    endfunction

    function automatic t_out corner32();
        case ($urandom_range(0, 4))
            0: return OUT_MIN;
            1: return OUT_MAX;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return t_out'($urandom);
        endcase
    endfunction

    function automatic t_wpart unit_part();
        return t_wpart'(int'($urandom_range(0, 23170)) - 11585);
    endfunction

    function automatic t_out modest_vec();
        return t_out'(int'($urandom_range(0, 33554431)) - 16777216);
    endfunction

    function automatic rot_word_t random_word();
        int      kind;
        rot_op_t op;
        kind = $urandom_range(0, 9);
        op   = rot_op_t'($urandom_range(0, 1));
        if (kind < 3)
            return word_of(op, t_wpart'($urandom), t_wpart'($urandom), t_wpart'($urandom),
                           t_wpart'($urandom), t_out'($urandom), t_out'($urandom),
                           t_out'($urandom));
        if (kind < 8)
            return word_of(op, unit_part(), unit_part(), unit_part(), unit_part(),
                           modest_vec(), modest_vec(), modest_vec());
        return word_of(op, corner16(), corner16(), corner16(), corner16(),
                       corner32(), corner32(), corner32());
    endfunction

    task automatic send_word(input rot_word_t w);
        int gap;
        if (words_sent % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.operation <= w.op;
        in_ch.quat_x    <= w.quat_x;
        in_ch.quat_y    <= w.quat_y;
        in_ch.quat_z    <= w.quat_z;
        in_ch.quat_w    <= w.quat_w;
        in_ch.vec_x     <= w.vec_x;
        in_ch.vec_y     <= w.vec_y;
        in_ch.vec_z     <= w.vec_z;
        in_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic drain_results();
        int taken;
        int stall;
        taken = 0;
        forever begin
            if (taken % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 7);
            if (taken == HOLD_AT) stall = LONG_HOLD;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    endtask

    initial begin
        int i;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_ROTATE;
        in_ch.quat_x    <= '0;
        in_ch.quat_y    <= '0;
        in_ch.quat_z    <= '0;
        in_ch.quat_w    <= '0;
        in_ch.vec_x     <= '0;
        in_ch.vec_y     <= '0;
        in_ch.vec_z     <= '0;
        out_ch.ready    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        send_word(word_of(OP_ROTATE, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                          32'sd65536, -32'sd65536, 32'sd123456));
        send_word(word_of(OP_INVERSE, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                          32'sd65536, -32'sd65536, 32'sd123456));
        send_word(word_of(OP_ROTATE, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585,
                          32'sd65536, 32'sd0, 32'sd0));
        send_word(word_of(OP_INVERSE, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585,
                          32'sd65536, 32'sd0, 32'sd0));
        send_word(word_of(OP_ROTATE, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585,
                          32'sd0, 32'sd131072, -32'sd98304));
        send_word(word_of(OP_INVERSE, 16'sd0, -16'sd11585, 16'sd0, 16'sd11585,
                          -32'sd40000, 32'sd7, 32'sd65536));
        send_word(word_of(OP_ROTATE, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                          32'sd0, 32'sd0, 32'sd0));
        send_word(word_of(OP_INVERSE, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                          OUT_MAX, OUT_MIN, -32'sd1));
        send_word(word_of(OP_ROTATE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                          OUT_MAX, OUT_MAX, OUT_MAX));
        send_word(word_of(OP_INVERSE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                          OUT_MIN, OUT_MIN, OUT_MIN));
        send_word(word_of(OP_ROTATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                          OUT_MIN, OUT_MAX, OUT_MIN));
        send_word(word_of(OP_INVERSE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                          OUT_MIN, OUT_MAX, OUT_MIN));
        send_word(word_of(OP_INVERSE, 16'sh8000, 16'sd0, 16'sd0, 16'sd16384,
                          32'sd0, 32'sd65536, 32'sd65536));
        send_word(word_of(OP_INVERSE, 16'sd0, 16'sh8000, 16'sh8000, 16'sd0,
                          32'sd65536, -32'sd65536, 32'sd1));
        send_word(word_of(OP_ROTATE, 16'sd0, 16'sd0, 16'sd0, 16'sh8000,
                          OUT_MAX, OUT_MIN, 32'sd65536));
        send_word(word_of(OP_ROTATE, 16'sd30000, -16'sd30000, 16'sd20000, 16'sd25000,
                          32'sd1000000, -32'sd2000000, 32'sd3000000));
        send_word(word_of(OP_ROTATE, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                          -32'sd1, -32'sd1, -32'sd1));
        send_word(word_of(OP_INVERSE, 16'sd1, -16'sd1, 16'sd1, 16'sd1,
                          32'sd1, -32'sd1, 32'sd1));
        send_word(word_of(OP_ROTATE, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                          32'sh55555555, 32'shaaaaaaaa, 32'sh55555555));
        send_word(word_of(OP_INVERSE, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                          32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa));

        for (i = 0; i < RANDOM_WORDS; i++) send_word(random_word());
        in_ch.valid <= 1'b0;

        do @(negedge i_clk); while (rotations_in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
